/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_ON_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/iprm_pkg.sv */
`default_nettype none

package iprm_pkg;

   localparam int MaxPacketBytesDefault = 2048;
   localparam int ProbesPerHopDefault   = 3;

   localparam logic [7:0] TypeEchoReply    = 8'd0;
   localparam logic [7:0] TypeTimeExceeded = 8'd11;

   localparam int IcmpHdrBytes  = 8;
   localparam int MinInnerBytes = 20;

   typedef enum logic [0:0] {
      CSR_PROBE_IDENT = 1'b0,
      CSR_HOP_LIMIT   = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      VERDICT_OK          = 3'd0,
      VERDICT_TOO_SHORT   = 3'd1,
      VERDICT_OTHER_TYPE  = 3'd2,
      VERDICT_ID_MISMATCH = 3'd3,
      VERDICT_HOP_MISMATCH = 3'd4,
      VERDICT_INDEX_LARGE = 3'd5
   } verdict_type;

   typedef enum logic [1:0] {
      KIND_ECHO_REPLY    = 2'd0,
      KIND_TIME_EXCEEDED = 2'd1,
      KIND_OTHER         = 2'd2
   } kind_type;

endpackage

`default_nettype wire

/* rtl/icmp_probe_reply_matcher.sv */
// Channel  Ports                                   Direction
// req      req_valid req_stall req_data_byte       in  (one packet byte per word)
//          req_last_byte
// rsp      rsp_valid rsp_stall rsp_accepted        out (one verdict word per packet)
//          rsp_verdict rsp_message_kind
//          rsp_sender_address rsp_probe_index
// csr      csr_write_enable csr_index csr_write_data  in
//
// One byte per cycle sustained while no verdict word is held; a byte word passes an input
// register and the packet state update in the next cycle. The verdict word is registered
// from the final byte in the input register.
// Reset is synchronous and active high; it clears packet state and restores the csr values.
// A stall on rsp holds a pending verdict; non-final bytes still advance, and a final
// byte waits in the input register, which then stalls req.
`default_nettype none

`include "assert_macros.svh"

module icmp_probe_reply_matcher
   import iprm_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = MaxPacketBytesDefault,
   parameter int PROBES_PER_HOP   = ProbesPerHopDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_accepted,
   output logic [2:0]       rsp_verdict,
   output logic [1:0]       rsp_message_kind,
   output logic [31:0]      rsp_sender_address,
   output logic [7:0]       rsp_probe_index,
   input  wire logic        csr_write_enable,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);

   localparam int PosW = $clog2(MAX_PACKET_BYTES + 1);
   localparam int CmpW = (PosW > 9) ? PosW : 9;

   logic [15:0]     ident_ff;
   logic [7:0]      hop_ff;

   logic            in_vld_ff;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;

   logic [PosW-1:0] pos_ff, pos_in;
   logic [5:0]      outer_ff, outer_in;
   logic [5:0]      inner_ff, inner_in;
   logic [7:0]      mtype_ff, mtype_in;
   logic [15:0]     eid_ff, eid_in;
   logic [15:0]     eseq_ff, eseq_in;
   logic [31:0]     src_ff, src_in;

   logic            out_vld_ff;
   logic            out_acc_ff;
   verdict_type     out_verdict_ff;
   kind_type        out_kind_ff;
   logic [31:0]     out_src_ff;
   logic [7:0]      out_idx_ff;

   logic            out_free;
   logic            proc;
   logic            take;
   logic [CmpW-1:0] pos_c;
   logic [CmpW-1:0] len_c;
   logic [CmpW-1:0] outer_c;
   logic [CmpW-1:0] inner_c;
   logic [CmpW-1:0] base_c;
   logic            base_ok;
   logic [5:0]      nib4;
   logic [7:0]      idx;
   verdict_type     verdict;
   kind_type        kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         ident_ff <= 16'd0;
         hop_ff   <= 8'd1;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PROBE_IDENT: ident_ff <= csr_write_data;
            CSR_HOP_LIMIT:   hop_ff   <= csr_write_data[7:0];
            default:         ;
         endcase
      end
   end

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign proc      = in_vld_ff && (!in_last_ff || out_free);
   assign req_stall = in_vld_ff && !proc;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_vld_ff <= 1'b1;
      end else if (proc) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   always_comb begin
      take     = pos_ff < PosW'(MAX_PACKET_BYTES);
      pos_c    = CmpW'(pos_ff);
      nib4     = {in_byte_ff[3:0], 2'b00};
      outer_in = outer_ff;
      inner_in = inner_ff;
      mtype_in = mtype_ff;
      eid_in   = eid_ff;
      eseq_in  = eseq_ff;
      src_in   = src_ff;
      pos_in   = pos_ff;
      base_c   = '0;
      base_ok  = 1'b0;
      if (take) begin
         pos_in = pos_ff + PosW'(1);
         if (pos_c == CmpW'(0)) begin
            outer_in = nib4;
         end
         case (pos_c)
            CmpW'(12): src_in[31:24] = in_byte_ff;
            CmpW'(13): src_in[23:16] = in_byte_ff;
            CmpW'(14): src_in[15:8]  = in_byte_ff;
            CmpW'(15): src_in[7:0]   = in_byte_ff;
            default:   ;
         endcase
         if (pos_c == CmpW'(outer_in)) begin
            mtype_in = in_byte_ff;
         end
         if (pos_c == CmpW'(outer_in) + CmpW'(IcmpHdrBytes)) begin
            inner_in = nib4;
         end
         if (mtype_in == TypeEchoReply) begin
            base_c  = CmpW'(outer_in);
            base_ok = 1'b1;
         end else if (mtype_in == TypeTimeExceeded) begin
            base_c  = CmpW'(outer_in) + CmpW'(IcmpHdrBytes) + CmpW'(inner_in);
            base_ok = 1'b1;
         end
         if (base_ok) begin
            if (pos_c == base_c + CmpW'(4)) eid_in[15:8]  = in_byte_ff;
            if (pos_c == base_c + CmpW'(5)) eid_in[7:0]   = in_byte_ff;
            if (pos_c == base_c + CmpW'(6)) eseq_in[15:8] = in_byte_ff;
            if (pos_c == base_c + CmpW'(7)) eseq_in[7:0]  = in_byte_ff;
         end
      end
   end

   always_comb begin
      len_c   = CmpW'(pos_in);
      outer_c = CmpW'(outer_in);
      inner_c = CmpW'(inner_in);
      idx     = eseq_in[7:0];
      if (len_c <= outer_c) begin
         kind = KIND_OTHER;
      end else if (mtype_in == TypeEchoReply) begin
         kind = KIND_ECHO_REPLY;
      end else if (mtype_in == TypeTimeExceeded) begin
         kind = KIND_TIME_EXCEEDED;
      end else begin
         kind = KIND_OTHER;
      end
      if (len_c < outer_c + CmpW'(IcmpHdrBytes)) begin
         verdict = VERDICT_TOO_SHORT;
      end else if (kind == KIND_OTHER) begin
         verdict = VERDICT_OTHER_TYPE;
      end else if (kind == KIND_TIME_EXCEEDED &&
                   (len_c < outer_c + CmpW'(2 * IcmpHdrBytes + MinInnerBytes) ||
                    len_c < outer_c + inner_c + CmpW'(2 * IcmpHdrBytes))) begin
         verdict = VERDICT_TOO_SHORT;
      end else if (eid_in != ident_ff) begin
         verdict = VERDICT_ID_MISMATCH;
      end else if (eseq_in[15:8] != hop_ff) begin
         verdict = VERDICT_HOP_MISMATCH;
      end else if (idx >= 8'(PROBES_PER_HOP)) begin
         verdict = VERDICT_INDEX_LARGE;
      end else begin
         verdict = VERDICT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         outer_ff <= '0;
         inner_ff <= '0;
         mtype_ff <= '0;
         eid_ff   <= '0;
         eseq_ff  <= '0;
         src_ff   <= '0;
      end else if (proc) begin
         if (in_last_ff) begin
            pos_ff   <= '0;
            outer_ff <= '0;
            inner_ff <= '0;
            mtype_ff <= '0;
            eid_ff   <= '0;
            eseq_ff  <= '0;
            src_ff   <= '0;
         end else begin
            pos_ff   <= pos_in;
            outer_ff <= outer_in;
            inner_ff <= inner_in;
            mtype_ff <= mtype_in;
            eid_ff   <= eid_in;
            eseq_ff  <= eseq_in;
            src_ff   <= src_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (proc && in_last_ff) begin
         out_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && in_last_ff) begin
         out_acc_ff     <= (verdict == VERDICT_OK);
         out_verdict_ff <= verdict;
         out_kind_ff    <= kind;
         out_src_ff     <= src_in;
         out_idx_ff     <= (verdict == VERDICT_TOO_SHORT || verdict == VERDICT_OTHER_TYPE)
                           ? 8'd0 : idx;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_accepted       = out_acc_ff;
   assign rsp_verdict        = out_verdict_ff;
   assign rsp_message_kind   = out_kind_ff;
   assign rsp_sender_address = out_src_ff;
   assign rsp_probe_index    = out_idx_ff;

   `ASSERT_ALWAYS(a_rsp_clear_after_reset, $past(reset) |-> !rsp_valid,
      "verdict word valid right after reset")
   `ASSERT_ON_CLK(a_pos_saturates, pos_ff <= PosW'(MAX_PACKET_BYTES),
      "byte count ran past its limit")
   `ASSERT_ON_CLK(a_accept_matches_verdict,
      rsp_valid |-> (rsp_accepted == (rsp_verdict == VERDICT_OK)),
      "accepted flag disagrees with verdict")
   `ASSERT_ON_CLK(a_idx_zero_on_drop,
      rsp_valid && (rsp_verdict == VERDICT_TOO_SHORT || rsp_verdict == VERDICT_OTHER_TYPE)
      |-> rsp_probe_index == 8'd0,
      "probe index set on an early drop")
   `ASSERT_ON_CLK(a_last_waits_on_full_out,
      in_vld_ff && in_last_ff && rsp_valid && rsp_stall |=> $stable(in_byte_ff) && in_vld_ff,
      "final byte left the input register while the verdict word was held")

endmodule

`default_nettype wire
